// ===== src/stfp_pkg.sv =====
package stfp_pkg;

    // Parser states.
    typedef enum logic [3:0] {
        ST_SEEK       = 4'd0,
        ST_METHOD     = 4'd1,
        ST_LINE       = 4'd2,
        ST_LINE_CR    = 4'd3,
        ST_KEY        = 4'd4,
        ST_VAL        = 4'd5,
        ST_BLANK_CR   = 4'd6,
        ST_BODY_START = 4'd7,
        ST_BODY_LEN   = 4'd8,
        ST_BODY_NUL   = 4'd9,
        ST_TAIL       = 4'd10
    } parse_state_t;

    // Event codes on event_res.
    localparam logic [3:0] EV_NONE        = 4'd0;
    localparam logic [3:0] EV_FRAME_START = 4'd1;
    localparam logic [3:0] EV_METHOD_CHAR = 4'd2;
    localparam logic [3:0] EV_METHOD_END  = 4'd3;
    localparam logic [3:0] EV_KEY_CHAR    = 4'd4;
    localparam logic [3:0] EV_KEY_END     = 4'd5;
    localparam logic [3:0] EV_VALUE_CHAR  = 4'd6;
    localparam logic [3:0] EV_VALUE_END   = 4'd7;
    localparam logic [3:0] EV_HEADERS_END = 4'd8;
    localparam logic [3:0] EV_BODY_BYTE   = 4'd9;
    localparam logic [3:0] EV_FRAME_END   = 4'd10;
    localparam logic [3:0] EV_ERROR       = 4'd11;

    // Error codes on error_code.
    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_BAD_LINE   = 3'd1;
    localparam logic [2:0] ERR_BAD_METHOD = 3'd2;
    localparam logic [2:0] ERR_BAD_FRAME  = 3'd3;
    localparam logic [2:0] ERR_TOO_BIG    = 3'd4;

    // Character constants.
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_C   = 8'h63;
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_DEL       = 8'h7F;

    localparam logic [15:0] MAX_TOKEN_LEN_RESET = 16'd4096;

    // Decoded escape: bit 8 says the escape is legal, bits 7:0 hold the character.
    function automatic logic [8:0] decode_escape(input logic [7:0] ch);
        logic [8:0] res;
        case (ch)
            CH_LOWER_N:   res = {1'b1, CH_LF};
            CH_LOWER_R:   res = {1'b1, CH_CR};
            CH_LOWER_C:   res = {1'b1, CH_COLON};
            CH_BACKSLASH: res = {1'b1, CH_BACKSLASH};
            default:      res = {1'b0, CH_NUL};
        endcase
        return res;
    endfunction

endpackage

// ===== src/stomp_frame_parser_unit.sv =====
// Channel   | Handshake             | Payload
// ----------+-----------------------+--------------------------------------------
// input     | in_valid / in_stall   | data_byte, content_length
// output    | out_valid / out_stall | event_res, char_out, error_code
// config    | cfg_wr_en             | cfg_wr_data (max_token_len)
//
// One byte is taken per cycle while in_stall is low. The parse logic sits between
// the input register and the result register, so a taken byte waits in the input
// register and its result is registered in the result register before it leaves.
// The parse state advances only when a byte moves from the input register
// into the result register, so throughput is one event per cycle while out_stall is low.
// Reset returns the parser to seeking a frame start, with max_token_len 4096.
// A stall on the output fills the input register; in_stall rises only when
// both the input and result registers hold an item and out_stall is high.
module stomp_frame_parser_unit #(
    parameter int BODY_LEN_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic [31:0] content_length,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic [7:0]  char_out,
    output logic [2:0]  error_code,

    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);
    import stfp_pkg::*;

    // Input register.
    logic        in_full_reg;
    logic [7:0]  byte_reg;
    logic [31:0] clen_reg;

    // Result register.
    logic        out_valid_reg;
    logic [3:0]  event_reg;
    logic [7:0]  char_reg;
    logic [2:0]  error_reg;

    // Parser state.
    parse_state_t             state_reg, state_next;
    logic                     esc_reg, esc_next;
    logic [15:0]              token_len_reg, token_len_next;
    logic [BODY_LEN_BITS-1:0] body_left_reg, body_left_next;
    logic [15:0]              max_tok_reg;

    logic advance;
    logic fire;
    logic in_accept;

    // Handshake: the pipeline moves when the result register is free or drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_full_reg && advance;
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign char_out   = char_reg;
    assign error_code = error_reg;

    // Content length reduced to the body counter width.
    logic [BODY_LEN_BITS-1:0] clen_masked;
    generate
        if (BODY_LEN_BITS >= 32)
        begin : g_clen_wide
            assign clen_masked = BODY_LEN_BITS'(clen_reg);
        end
        else
        begin : g_clen_narrow
            assign clen_masked = clen_reg[BODY_LEN_BITS-1:0];
        end
    endgenerate

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_tok_reg <= MAX_TOKEN_LEN_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_tok_reg <= cfg_wr_data;
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_full_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_full_reg <= 1'b0;
        end
    end

    // Input payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= data_byte;
            clen_reg <= content_length;
        end
    end

    // Parse logic: event and next state for the byte in the input register.
    logic [3:0]  ev;
    logic [7:0]  ev_ch;
    logic [2:0]  ev_err;
    logic        push_req;
    logic [3:0]  push_ev;
    logic [7:0]  push_ch;
    logic [15:0] push_base;
    logic        do_fail;
    logic [2:0]  fail_code;
    logic        key_go;
    logic        key_esc;
    logic [8:0]  esc_dec;
    logic [7:0]  ch;
    logic        is_upper;
    logic        is_line_end;
    logic [BODY_LEN_BITS-1:0] body_dec;

    always_comb
    begin
        ch             = byte_reg;
        state_next     = state_reg;
        esc_next       = esc_reg;
        token_len_next = token_len_reg;
        body_left_next = body_left_reg;
        ev             = EV_NONE;
        ev_ch          = CH_NUL;
        ev_err         = ERR_NONE;
        push_req       = 1'b0;
        push_ev        = EV_NONE;
        push_ch        = CH_NUL;
        push_base      = token_len_reg;
        do_fail        = 1'b0;
        fail_code      = ERR_NONE;
        key_go         = 1'b0;
        key_esc        = esc_reg;
        esc_dec        = decode_escape(ch);
        is_upper       = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
        is_line_end    = (ch == CH_LF) || (ch == CH_CR);
        body_dec       = body_left_reg - BODY_LEN_BITS'(1);

        unique case (state_reg)
            ST_SEEK:
            begin
                if (is_line_end || ch == CH_NUL)
                begin
                    ev = EV_NONE;
                end
                else if (is_upper)
                begin
                    esc_next       = 1'b0;
                    body_left_next = '0;
                    state_next     = ST_METHOD;
                    push_req       = 1'b1;
                    push_ev        = EV_FRAME_START;
                    push_ch        = ch;
                    push_base      = '0;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_LINE;
                end
            end
            ST_METHOD:
            begin
                if (is_upper)
                begin
                    push_req = 1'b1;
                    push_ev  = EV_METHOD_CHAR;
                    push_ch  = ch;
                end
                else if (is_line_end)
                begin
                    token_len_next = '0;
                    state_next     = (ch == CH_LF) ? ST_LINE : ST_LINE_CR;
                    ev             = EV_METHOD_END;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_METHOD;
                end
            end
            ST_LINE:
            begin
                if (ch == CH_CR)
                begin
                    state_next = ST_BLANK_CR;
                end
                else if (ch == CH_LF)
                begin
                    state_next = ST_BODY_START;
                    ev         = EV_HEADERS_END;
                end
                else if (ch > CH_SPACE && ch < CH_DEL)
                begin
                    // The first byte of a header line is a key byte.
                    esc_next       = 1'b0;
                    token_len_next = '0;
                    state_next     = ST_KEY;
                    key_go         = 1'b1;
                    key_esc        = 1'b0;
                    push_base      = '0;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_LINE;
                end
            end
            ST_LINE_CR:
            begin
                if (ch == CH_LF)
                begin
                    state_next = ST_LINE;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_LINE;
                end
            end
            ST_KEY:
            begin
                key_go = 1'b1;
            end
            ST_VAL:
            begin
                if (esc_reg)
                begin
                    if (esc_dec[8])
                    begin
                        esc_next = 1'b0;
                        push_req = 1'b1;
                        push_ev  = EV_VALUE_CHAR;
                        push_ch  = esc_dec[7:0];
                    end
                    else
                    begin
                        do_fail   = 1'b1;
                        fail_code = ERR_BAD_FRAME;
                    end
                end
                else if (ch >= CH_SPACE && ch < CH_DEL)
                begin
                    if (ch == CH_BACKSLASH)
                    begin
                        esc_next = 1'b1;
                    end
                    else
                    begin
                        push_req = 1'b1;
                        push_ev  = EV_VALUE_CHAR;
                        push_ch  = ch;
                    end
                end
                else if (is_line_end)
                begin
                    token_len_next = '0;
                    state_next     = (ch == CH_LF) ? ST_LINE : ST_LINE_CR;
                    ev             = EV_VALUE_END;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_FRAME;
                end
            end
            ST_BLANK_CR:
            begin
                if (ch == CH_LF)
                begin
                    state_next = ST_BODY_START;
                    ev         = EV_HEADERS_END;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_LINE;
                end
            end
            ST_BODY_START:
            begin
                if (ch == CH_NUL)
                begin
                    state_next = ST_SEEK;
                    ev         = EV_FRAME_END;
                end
                else if (clen_masked != '0)
                begin
                    body_left_next = clen_masked - BODY_LEN_BITS'(1);
                    state_next     = (clen_masked == BODY_LEN_BITS'(1)) ? ST_TAIL
                                                                        : ST_BODY_LEN;
                    ev             = EV_BODY_BYTE;
                    ev_ch          = ch;
                end
                else
                begin
                    state_next = ST_BODY_NUL;
                    ev         = EV_BODY_BYTE;
                    ev_ch      = ch;
                end
            end
            ST_BODY_LEN:
            begin
                body_left_next = body_dec;
                if (body_dec == '0)
                begin
                    state_next = ST_TAIL;
                end
                ev    = EV_BODY_BYTE;
                ev_ch = ch;
            end
            ST_BODY_NUL:
            begin
                if (ch == CH_NUL)
                begin
                    state_next = ST_SEEK;
                    ev         = EV_FRAME_END;
                end
                else
                begin
                    ev    = EV_BODY_BYTE;
                    ev_ch = ch;
                end
            end
            ST_TAIL:
            begin
                if (ch == CH_NUL)
                begin
                    state_next = ST_SEEK;
                    ev         = EV_FRAME_END;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_FRAME;
                end
            end
            default:
            begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_FRAME;
            end
        endcase

        // Header key byte, shared by the key state and the start of a line.
        if (key_go)
        begin
            if (key_esc)
            begin
                if (esc_dec[8])
                begin
                    esc_next = 1'b0;
                    push_req = 1'b1;
                    push_ev  = EV_KEY_CHAR;
                    push_ch  = esc_dec[7:0];
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = ERR_BAD_FRAME;
                end
            end
            else if (ch == CH_BACKSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (ch == CH_COLON)
            begin
                token_len_next = '0;
                state_next     = ST_VAL;
                ev             = EV_KEY_END;
            end
            else if (is_line_end)
            begin
                // A key line without a colon is dropped silently.
                token_len_next = '0;
                state_next     = (ch == CH_LF) ? ST_LINE : ST_LINE_CR;
            end
            else if (ch > CH_SPACE && ch < CH_DEL)
            begin
                push_req = 1'b1;
                push_ev  = EV_KEY_CHAR;
                push_ch  = ch;
            end
            else
            begin
                do_fail   = 1'b1;
                fail_code = ERR_BAD_FRAME;
            end
        end

        // Token character append with the length limit.
        if (push_req)
        begin
            if (push_base >= max_tok_reg)
            begin
                do_fail   = 1'b1;
                fail_code = ERR_TOO_BIG;
            end
            else
            begin
                token_len_next = push_base + 16'd1;
                ev             = push_ev;
                ev_ch          = push_ch;
            end
        end

        // Any error reports itself and returns to seeking a frame start.
        if (do_fail)
        begin
            ev             = EV_ERROR;
            ev_ch          = CH_NUL;
            ev_err         = fail_code;
            state_next     = ST_SEEK;
            esc_next       = 1'b0;
            token_len_next = '0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SEEK;
            esc_reg       <= 1'b0;
            token_len_reg <= '0;
            body_left_reg <= '0;
        end
        else if (fire)
        begin
            state_reg     <= state_next;
            esc_reg       <= esc_next;
            token_len_reg <= token_len_next;
            body_left_reg <= body_left_next;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            event_reg <= ev;
            char_reg  <= ev_ch;
            error_reg <= ev_err;
        end
    end

endmodule
